// ===== src/ftl_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the key table.
`timescale 1ns / 1ps

package ftl_pkg;

   localparam int ENTRIES_DEFAULT  = 64;
   localparam int KEY_BITS_DEFAULT = 32;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 32;
   localparam int LEN_W    = 3;
   localparam int CNT_W    = 16;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // result selection for the pending result register
   localparam logic [2:0] RES_OK_ZERO = 3'd0;
   localparam logic [2:0] RES_MISS    = 3'd1;
   localparam logic [2:0] RES_FULL    = 3'd2;
   localparam logic [2:0] RES_APPEND  = 3'd3;
   localparam logic [2:0] RES_HIT     = 3'd4;

   typedef struct packed {
      logic       load_req;
      logic       append;
      logic       clear;
      logic       scan_start;
      logic       scan_next;
      logic       hit;
      logic       wr_lo;
      logic       wr_hi;
      logic       res_load;
      logic [2:0] res_sel;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              empty;
      logic              full;
      logic              match;
      logic              last;
      logic              swap;
   } stat_type;

endpackage

// ===== src/ftl_ctrl.sv =====
// Controller state machine: sequences append, clear, lookup scan, swap writes and the response.
`timescale 1ns / 1ps

module ftl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  ftl_pkg::stat_type stat,
   output ftl_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_WR_LO = 3'd3;
   localparam logic [2:0] S_WR_HI = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_sel = ftl_pkg::RES_OK_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (stat.func)
               ftl_pkg::FUNC_APPEND: begin
                  cmd.res_load = 1'b1;
                  if (stat.full) begin
                     cmd.res_sel = ftl_pkg::RES_FULL;
                  end else begin
                     cmd.res_sel = ftl_pkg::RES_APPEND;
                     cmd.append  = 1'b1;
                  end
                  state_in = S_RESP;
               end
               ftl_pkg::FUNC_LOOKUP: begin
                  if (stat.empty) begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = ftl_pkg::RES_MISS;
                     state_in     = S_RESP;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               ftl_pkg::FUNC_CLEAR: begin
                  cmd.clear    = 1'b1;
                  cmd.res_load = 1'b1;
                  state_in     = S_RESP;
               end
               default: begin
                  cmd.res_load = 1'b1;
                  state_in     = S_RESP;
               end
            endcase
         end
         S_SCAN: begin
            priority if (stat.match) begin
               cmd.hit      = 1'b1;
               cmd.res_load = 1'b1;
               cmd.res_sel  = ftl_pkg::RES_HIT;
               state_in     = S_WR_LO;
            end else if (stat.last) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = ftl_pkg::RES_MISS;
               state_in     = S_RESP;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_WR_LO: begin
            cmd.wr_lo = 1'b1;
            state_in  = stat.swap ? S_WR_HI : S_RESP;
         end
         S_WR_HI: begin
            cmd.wr_hi = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/ftl_datapath.sv =====
// Datapath: entry memory, request and scan registers, swap buffers and response registers.
`timescale 1ns / 1ps

module ftl_datapath #(
   parameter int ENTRIES  = ftl_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = ftl_pkg::KEY_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ftl_pkg::FUNC_W-1:0]   req_func,
   input  logic [ftl_pkg::KEY_W-1:0]    req_key,
   input  logic [ftl_pkg::LEN_W-1:0]    req_len,
   input  ftl_pkg::cmd_type             cmd,
   output ftl_pkg::stat_type            stat,
   output logic [ftl_pkg::STATUS_W-1:0] rsp_status,
   output logic [ftl_pkg::INDEX_W-1:0]  rsp_index
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int LW = ftl_pkg::LEN_W;
   localparam int NW = ftl_pkg::CNT_W;
   localparam int EW = KEY_BITS + LW + NW;

   // entry layout: {key, length, count}
   logic [EW-1:0] mem [ENTRIES];

   localparam int FUNC_W_LOCAL = ftl_pkg::FUNC_W;
   logic [FUNC_W_LOCAL-1:0] func_ff;

   logic [KEY_BITS-1:0] key_ext, key_masked;
   logic [KEY_BITS-1:0] key_ff;
   logic [LW-1:0]       len_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       rd_addr;
   logic [EW-1:0]       rd_data_ff;
   logic [EW-1:0]       prev_ff;
   logic [EW-1:0]       hit_ff;
   logic                swap_ff;
   logic [NW-1:0]       cnt_new;
   logic                swap_now;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [EW-1:0]       wr_data;
   logic [ftl_pkg::STATUS_W-1:0] res_status_ff;
   logic [ftl_pkg::INDEX_W-1:0]  res_index_ff;
   logic [ftl_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ftl_pkg::INDEX_W-1:0]  rsp_index_ff;

   assign key_ext = KEY_BITS'(req_key);

   // keep only the bytes below key_len
   always_comb begin
      for (int j = 0; j < KEY_BITS; j++) begin
         key_masked[j] = key_ext[j] & ({1'b0, req_len} > 4'(j >> 3));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         key_ff  <= key_masked;
         len_ff  <= req_len;
      end
   end

   // scan: address runs one ahead of the entry being compared
   assign rd_addr = cmd.scan_start ? '0 : AW'(idx_ff + 1'b1);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.scan_next) begin
         idx_in = AW'(idx_ff + 1'b1);
      end
   end

   assign cnt_new  = (rd_data_ff[NW-1:0] == ftl_pkg::COUNT_MAX) ?
                     rd_data_ff[NW-1:0] : NW'(rd_data_ff[NW-1:0] + 1'b1);
   assign swap_now = (idx_ff != '0) && (cnt_new > prev_ff[NW-1:0]);

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.scan_next) begin
         prev_ff <= rd_data_ff;
      end
      if (cmd.hit) begin
         hit_ff  <= {rd_data_ff[EW-1:NW], cnt_new};
         swap_ff <= swap_now;
      end
   end

   always_comb begin
      wr_en   = cmd.append | cmd.wr_lo | cmd.wr_hi;
      wr_addr = idx_ff;
      wr_data = prev_ff;
      priority if (cmd.append) begin
         wr_addr = AW'(count_ff);
         wr_data = {key_ff, len_ff, {NW{1'b0}}};
      end else if (cmd.wr_lo) begin
         wr_addr = swap_ff ? AW'(idx_ff - 1'b1) : idx_ff;
         wr_data = hit_ff;
      end else begin
         wr_addr = idx_ff;
         wr_data = prev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = CW'(count_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         unique case (cmd.res_sel)
            ftl_pkg::RES_MISS: begin
               res_status_ff <= ftl_pkg::STATUS_MISS;
               res_index_ff  <= '0;
            end
            ftl_pkg::RES_FULL: begin
               res_status_ff <= ftl_pkg::STATUS_FULL;
               res_index_ff  <= '0;
            end
            ftl_pkg::RES_APPEND: begin
               res_status_ff <= ftl_pkg::STATUS_OK;
               res_index_ff  <= ftl_pkg::INDEX_W'(count_ff);
            end
            ftl_pkg::RES_HIT: begin
               res_status_ff <= ftl_pkg::STATUS_OK;
               res_index_ff  <= ftl_pkg::INDEX_W'(idx_ff);
            end
            default: begin
               res_status_ff <= ftl_pkg::STATUS_OK;
               res_index_ff  <= '0;
            end
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;

   always_comb begin
      stat.func  = func_ff;
      stat.empty = (count_ff == '0);
      stat.full  = (count_ff == CW'(ENTRIES));
      stat.match = (rd_data_ff[EW-1:NW] == {key_ff, len_ff});
      stat.last  = (CW'(idx_ff) + CW'(1) == count_ff);
      stat.swap  = swap_ff;
   end

endmodule

// ===== src/frequency_transpose_list_top.sv =====
// Top level of the count-transpose self-organizing key table.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_*): one transaction per operation. req_tuser carries the
//   operation (append, lookup, clear); req_tdata carries the key and its byte length.
//   Response channel (rsp_*): exactly one transaction per request, in order, with the
//   status in rsp_tuser and the entry position in rsp_tdata.
//   Append, clear and the unused code go from execution straight to the response. A
//   lookup reads one entry per cycle from the entry memory, comparing each filled
//   entry in order until a match or the last one; a hit writes the entry back with
//   its count raised (saturating), and a second memory write is needed when the
//   entry trades places with its predecessor.
//   One request is worked at a time; req_tready is high only while the block idles.
//   A finished response sits in the output register; the next request can be taken
//   meanwhile, and its result waits until the receiver takes the earlier one.
//   Reset (synchronous, active high) empties the table and drops any pending
//   response. Memory contents are not cleared; only entries below the fill count
//   are ever compared.

module frequency_transpose_list_top #(
   parameter int ENTRIES  = ftl_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = ftl_pkg::KEY_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ftl_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] key, [34:32] key_len, pad
   input  logic [ftl_pkg::FUNC_W-1:0]     req_tuser,  // [1:0] func
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ftl_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [5:0] index, pad
   output logic [ftl_pkg::STATUS_W-1:0]   rsp_tuser   // [1:0] status
);

   ftl_pkg::cmd_type  cmd;
   ftl_pkg::stat_type stat;
   logic [ftl_pkg::INDEX_W-1:0] rsp_index;

   ftl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ftl_datapath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_func   (req_tuser),
      .req_key    (req_tdata[ftl_pkg::KEY_W-1:0]),
      .req_len    (req_tdata[ftl_pkg::KEY_W +: ftl_pkg::LEN_W]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_tuser),
      .rsp_index  (rsp_index)
   );

   assign rsp_tdata = ftl_pkg::RSP_DATA_W'(rsp_index);

endmodule
